// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package swm_pkg;

	typedef struct packed {
		logic load;
		logic clear;
	} swm_ctrl_t;

	localparam int WLEN_W = 7;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd1;

	typedef enum logic {
		REG_WINDOW_LEN = 1'b0,
		REG_UNUSED     = 1'b1
	} swm_reg_t;

endpackage

// ===== rtl/swm_cell.sv =====
// One cell of the sample shift line: holds one past sample and its candidate flag.
// Depends on swm_pkg for the control struct.
`timescale 1ns / 1ps

module swm_cell #(
	parameter int DW  = 32,
	parameter int KW  = 7,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swm_pkg::swm_ctrl_t  ctrl,
	input  logic [DW-1:0]       sample,
	input  logic [KW-1:0]       win,
	input  logic                prev_cand,
	input  logic [DW-1:0]       prev_val,
	output logic                cand,
	output logic [DW-1:0]       val,
	output logic                nxt_cand,
	output logic [DW-1:0]       nxt_val
);
	import swm_pkg::*;

	logic cand_q;
	logic [DW-1:0] val_q;
	logic less;
	logic live;

	// drop smaller values and values that leave the window
	assign less = $signed(prev_val) < $signed(sample);
	assign live = KW'(IDX) < win;
	assign nxt_cand = prev_cand & ~less & live;
	assign nxt_val = prev_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (ctrl.load) begin
			cand_q <= nxt_cand & ~ctrl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= nxt_val;
		end
	end

	assign cand = cand_q;
	assign val = val_q;

endmodule

// ===== rtl/swm_pick.sv =====
// One registered node of the front search tree: keeps the older candidate.
// No dependencies.
`timescale 1ns / 1ps

module swm_pick #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic          young_cand,
	input  logic [DW-1:0] young_val,
	input  logic          old_cand,
	input  logic [DW-1:0] old_val,
	output logic          cand,
	output logic [DW-1:0] val
);
	logic cand_q;
	logic [DW-1:0] val_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cand_q <= young_cand | old_cand;
			val_q <= old_cand ? old_val : young_val;
		end
	end

	assign cand = cand_q;
	assign val = val_q;

endmodule

// ===== rtl/sliding_window_max.sv =====
// Sliding window maximum: cell chain over the last WINDOW_MAX samples plus search tree.
// Depends on swm_pkg, swm_cell and swm_pick.
`timescale 1ns / 1ps
//
// Usage:
//   Samples enter on s_tdata (sample) with s_tlast marking the final sample of a
//   sequence. Once a sequence has window_len samples, each sample yields one item
//   on m_tdata (window_max) with m_tlast copying the sample's s_tlast.
//   window_len is written over APB at address 0 (0 acts as 1 but reads as 0, values
//   above WINDOW_MAX act as WINDOW_MAX); write it only while no item is in flight.
//   Throughput: one sample per clock while s_tready is high. Each sample
//   shifts the cell chain and clears the flags of cells it dominates or that
//   aged out of the window. The front search tree has $clog2(WINDOW_MAX)
//   register stages between the accepting edge and the result.
//   When m_tready is low, results hold and the tree stages fill up; s_tready
//   drops only once every stage holds a result.
//   Reset clears the sequence state and sets window_len to 1; no clearing pass.

module sliding_window_max #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// s_tdata: sample
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
	input  logic                                   s_tlast,
	// m_tdata: window_max
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,
	output logic                                   m_tlast,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import swm_pkg::*;

	localparam int DW  = SAMPLE_WIDTH;
	localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int KW  = $clog2(WINDOW_MAX + 1);
	localparam int LVL = $clog2(WINDOW_MAX);
	localparam int P   = 2 ** LVL;

	logic [WLEN_W-1:0] wlen_q;
	logic [KW-1:0] win;
	logic [KW-1:0] fcnt_q;
	logic [KW-1:0] fcnt_nxt;
	logic emit;
	logic accept;
	logic [DW-1:0] sample;
	swm_ctrl_t ctrl;
	swm_reg_t reg_idx;

	logic cq [WINDOW_MAX];
	logic [DW-1:0] vq [WINDOW_MAX];
	logic tc [1:2*P-1];
	logic [DW-1:0] tv [1:2*P-1];

	logic [LVL-1:0] en;
	logic [LVL-1:0] vld_q;
	logic [LVL-1:0] lst_q;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = swm_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_WINDOW_LEN) begin
			wlen_q <= pwdata[WLEN_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_LEN: prdata = 32'(wlen_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (wlen_q == '0) begin
			win = KW'(1);
		end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
			win = KW'(WINDOW_MAX);
		end else begin
			win = KW'(wlen_q);
		end
	end

	// handshake and fill count
	assign sample = s_tdata[DW-1:0];
	assign accept = s_tvalid && s_tready;
	assign ctrl.load = accept;
	assign ctrl.clear = s_tlast;

	assign fcnt_nxt = (fcnt_q == KW'(WINDOW_MAX)) ? fcnt_q : fcnt_q + KW'(1);
	assign emit = fcnt_nxt >= win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (accept) begin
			fcnt_q <= s_tlast ? '0 : fcnt_nxt;
		end
	end

	// cell chain
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic pc;
		logic [DW-1:0] pv;
		if (i == 0) begin : g_head
			assign pc = 1'b1;
			assign pv = sample;
		end else begin : g_link
			assign pc = cq[i-1];
			assign pv = vq[i-1];
		end
		swm_cell #(
			.DW  (DW),
			.KW  (KW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sample    (sample),
			.win       (win),
			.prev_cand (pc),
			.prev_val  (pv),
			.cand      (cq[i]),
			.val       (vq[i]),
			.nxt_cand  (tc[P+i]),
			.nxt_val   (tv[P+i])
		);
	end

	for (genvar j = WINDOW_MAX; j < P; j++) begin : g_pad
		assign tc[P+j] = 1'b0;
		assign tv[P+j] = '0;
	end

	// front search tree, oldest candidate wins
	for (genvar n = 1; n < P; n++) begin : g_node
		swm_pick #(
			.DW (DW)
		) u_pick (
			.clk        (clk),
			.en         (en[$clog2(n+1)-1]),
			.young_cand (tc[2*n]),
			.young_val  (tv[2*n]),
			.old_cand   (tc[2*n+1]),
			.old_val    (tv[2*n+1]),
			.cand       (tc[n]),
			.val        (tv[n])
		);
	end

	always_comb begin
		en[0] = !vld_q[0] || m_tready;
		for (int d = 1; d < LVL; d++) begin
			en[d] = !vld_q[d] || en[d-1];
		end
	end

	assign s_tready = en[LVL-1];

	for (genvar d = 0; d < LVL; d++) begin : g_stage
		if (d == LVL - 1) begin : g_entry
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[d] <= 1'b0;
				end else if (en[d]) begin
					vld_q[d] <= accept && emit;
				end
			end
			always_ff @(posedge clk) begin
				if (en[d]) begin
					lst_q[d] <= s_tlast;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[d] <= 1'b0;
				end else if (en[d]) begin
					vld_q[d] <= vld_q[d+1];
				end
			end
			always_ff @(posedge clk) begin
				if (en[d]) begin
					lst_q[d] <= lst_q[d+1];
				end
			end
		end
	end

	assign m_tvalid = vld_q[0];
	assign m_tdata = TDW'(tv[1]);
	assign m_tlast = lst_q[0];

endmodule

// ===== tb/tb_sliding_window_max.sv =====
// Self-checking testbench for sliding_window_max: directed table, then random sample runs.
// Window maxima are predicted by a candidate queue kept here; depends on swm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sliding_window_max;
	import swm_pkg::*;

	localparam int DEPTH = 64;
	localparam int POS_WRAP = 2 * DEPTH;
	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_OFF = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int EXP_DEPTH = 64;
	localparam int DIR_DEPTH = 32;
	localparam logic [2:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = {REG_UNUSED, 2'b00};

	typedef struct packed {
		logic [31:0] mx;
		logic        lst;
	} max_result_t;

	typedef struct packed {
		int          wcfg;
		logic [31:0] smp;
		logic        lst;
		bit          typed;
		logic [31:0] mx;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sliding_window_max u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] sample
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] window_max
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// predictor state: candidate queue of the current sequence
	logic signed [31:0] cand_val [DEPTH];
	int                 cand_pos [DEPTH];
	int                 cand_head = 0;
	int                 cand_cnt = 0;
	int                 next_pos = 0;
	int                 seen_cnt = 0;
	logic [6:0]         win_len = WLEN_RESET;

	max_result_t exp_buf [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;
	stim_row_t   dir_rows [DIR_DEPTH];
	int          dir_cnt = 0;
	bit          calm = 1'b0;
	int          errors = 0;
	int          checked = 0;
	int          items_sent = 0;
	int          cfg_writes = 0;
	int          cycles = 0;
	logic [31:0] prev_smp = '0;

	function automatic void exp_store(input max_result_t r);
		exp_buf[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	function automatic max_result_t exp_fetch();
		max_result_t r;
		r = exp_buf[exp_rd % EXP_DEPTH];
		exp_rd++;
		return r;
	endfunction

	function automatic int exp_level();
		return exp_wr - exp_rd;
	endfunction

	function automatic void predict_window_max(input logic signed [31:0] smp, input logic lst,
			output bit has, output max_result_t res);
		int k;
		int cur;
		k = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
		cur = next_pos;
		// drop candidates that aged out of the window
		while (cand_cnt > 0 && ((cur + POS_WRAP - cand_pos[cand_head]) % POS_WRAP) >= k) begin
			cand_head = (cand_head + 1) % DEPTH;
			cand_cnt--;
		end
		// drop smaller candidates from the back, keep equal ones
		while (cand_cnt > 0 && cand_val[(cand_head + cand_cnt - 1) % DEPTH] < smp)
			cand_cnt--;
		if (cand_cnt >= DEPTH) begin
			cand_head = (cand_head + 1) % DEPTH;
			cand_cnt--;
		end
		cand_val[(cand_head + cand_cnt) % DEPTH] = smp;
		cand_pos[(cand_head + cand_cnt) % DEPTH] = cur;
		cand_cnt++;
		next_pos = (cur + 1) % POS_WRAP;
		if (seen_cnt < DEPTH)
			seen_cnt++;
		has = (seen_cnt >= k);
		res.mx = cand_val[cand_head];
		res.lst = lst;
		if (lst) begin
			cand_head = 0;
			cand_cnt = 0;
			next_pos = 0;
			seen_cnt = 0;
		end
	endfunction

	task automatic push_sample(input logic [31:0] smp, input logic lst, input bit typed,
			input logic [31:0] typed_mx);
		bit has;
		max_result_t res;
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_window_max(smp, lst, has, res);
		if (typed) begin
			res.mx = typed_mx;
			res.lst = lst;
		end
		if (has || typed)
			exp_store(res);
		items_sent++;
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		s_tvalid <= 1'b0;
		while (exp_level() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW_LEN)
			win_len = data[6:0];
		cfg_writes++;
	endtask

	task automatic add_row(input int wcfg, input logic [31:0] smp, input logic lst,
			input bit typed, input logic [31:0] mx);
		stim_row_t r;
		r.wcfg = wcfg;
		r.smp = smp;
		r.lst = lst;
		r.typed = typed;
		r.mx = mx;
		dir_rows[dir_cnt] = r;
		dir_cnt++;
	endtask

	function automatic logic [31:0] next_sample();
		logic [31:0] v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			v = $urandom;
		else if (pick < 55)
			v = $urandom_range(7) - 4;
		else if (pick < 65) begin
			case ($urandom_range(3))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'h0000_0000;
				default: v = 32'hFFFF_FFFF;
			endcase
		end else
			v = prev_smp + ($urandom_range(16) - 8);
		prev_smp = v;
		return v;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, exp_level());
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		max_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_level() == 0) begin
				$display("%0t unexpected item: expected none actual max %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				want = exp_fetch();
				if (m_tdata !== want.mx) begin
					$display("%0t window_max mismatch: expected %h actual %h",
						$time, want.mx, m_tdata);
					errors++;
				end
				if (m_tlast !== want.lst) begin
					$display("%0t last_result mismatch: expected %b actual %b",
						$time, want.lst, m_tlast);
					errors++;
				end
				checked++;
			end
		end
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
	end

	initial begin
		int rand_items;
		int phase;
		int w;
		int keff;
		int budget;
		int n;
		int len;
		bit close_seq;
		logic [31:0] smp;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window 1 after reset, then 0 which acts as 1
		add_row(-1, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF);
		add_row(-1, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000);
		add_row(-1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		add_row(0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000);
		add_row(-1, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678);
		// window 3: equal values, extremes, short sequences
		add_row(3, 32'd5, 1'b0, 1'b0, '0);
		add_row(-1, 32'd5, 1'b0, 1'b0, '0);
		add_row(-1, 32'd5, 1'b0, 1'b0, '0);
		add_row(-1, 32'h8000_0000, 1'b0, 1'b0, '0);
		add_row(-1, 32'h8000_0000, 1'b0, 1'b0, '0);
		add_row(-1, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
		add_row(-1, 32'd3, 1'b1, 1'b0, '0);
		add_row(-1, 32'd9, 1'b1, 1'b0, '0);
		add_row(-1, 32'd1, 1'b0, 1'b0, '0);
		add_row(-1, 32'd2, 1'b1, 1'b0, '0);
		add_row(-1, 32'd4, 1'b0, 1'b0, '0);
		add_row(-1, 32'd6, 1'b0, 1'b0, '0);
		// window changes inside an open sequence, including above the maximum
		add_row(65, 32'd7, 1'b0, 1'b0, '0);
		add_row(2, 32'd1, 1'b0, 1'b0, '0);
		add_row(-1, 32'd0, 1'b1, 1'b0, '0);
		add_row(127, 32'd8, 1'b1, 1'b0, '0);
		add_row(1, 32'hFFFF_FFFB, 1'b0, 1'b1, 32'hFFFF_FFFB);

		for (int i = 0; i < dir_cnt; i++) begin
			if (dir_rows[i].wcfg >= 0)
				write_reg(ADDR_WINDOW_LEN, ($urandom & 32'hFFFF_FF80) | dir_rows[i].wcfg);
			push_sample(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].mx);
		end

		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case (phase)
				0: w = 64;
				1: w = 127;
				2: w = 1;
				3: w = 2;
				default: begin
					case ($urandom_range(9))
						0: w = 0;
						1: w = 1;
						2: w = 2;
						3: w = 64;
						4: w = $urandom_range(127, 65);
						default: w = $urandom_range(20, 3);
					endcase
				end
			endcase
			write_reg(ADDR_WINDOW_LEN, ($urandom & 32'hFFFF_FF80) | w);
			if (phase == 2)
				write_reg(ADDR_UNUSED, $urandom);
			keff = (w == 0) ? 1 : ((w > DEPTH) ? DEPTH : w);
			budget = $urandom_range(220, 80);
			n = 0;
			while (n < budget) begin
				case ($urandom_range(19))
					0, 1, 2: len = (keff > 1) ? $urandom_range(keff - 1, 1) : 1;
					3, 4, 5, 6, 7, 8, 9, 10, 11, 12: len = $urandom_range(3 * keff, keff);
					default: len = $urandom_range(3 * keff + 20, keff);
				endcase
				close_seq = ($urandom_range(99) < 85);
				for (int j = 0; j < len; j++) begin
					calm = (rand_items >= 700 && rand_items < 1000);
					smp = next_sample();
					push_sample(smp, close_seq && (j == len - 1), 1'b0, '0);
					rand_items++;
					n++;
				end
			end
			phase++;
		end

		calm = 1'b0;
		s_tvalid <= 1'b0;
		while (exp_level() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d samples over %0d register writes; %0d window maxima compared",
			items_sent, cfg_writes, checked);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
